/* rtl/core/cmrd_pkg.sv */
// ----------------------------------------------------------------------------
// cmrd_pkg
// Shared types, constants and the PEC byte update for the readback deframer.
// ----------------------------------------------------------------------------
package cmrd_pkg;

    localparam int MAX_CHIPS      = 16;
    localparam int CHAIN_W        = 5;
    localparam int CHIP_W         = 4;
    localparam int POS_W          = 3;
    localparam int INDEX_W        = 8;

    localparam logic [15:0] PEC_SEED = 16'h0010;
    localparam logic [15:0] PEC_POLY = 16'h4599;

    localparam logic [POS_W-1:0] POS_PEC_HIGH = 3'd6;
    localparam logic [POS_W-1:0] POS_PEC_LOW  = 3'd7;

    localparam logic [CHAIN_W-1:0] CHAIN_MIN   = 5'd1;
    localparam logic [CHAIN_W-1:0] CHAIN_MAX   = 5'(MAX_CHIPS);
    localparam logic [CHAIN_W-1:0] CHAIN_RESET = 5'd1;

    localparam logic MODE_CELL = 1'b0;
    localparam logic MODE_AUX  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       mode;
        logic [1:0] group;
        logic       frame_start;
    } item_t;

    typedef struct packed {
        logic [15:0]        code_first;
        logic [15:0]        code_second;
        logic [15:0]        code_third;
        logic [INDEX_W-1:0] first_index;
        logic               pec_ok;
        logic               last;
    } result_t;

    // CRC-15 remainder update for one byte, kept at 16 bits
    function automatic logic [15:0] pec_update(input logic [15:0] rem,
                                               input logic [7:0]  data);
        logic [15:0] t;
        t = {1'b0, rem[14:7] ^ data, 7'b0};
        for (int b = 0; b < 8; b++)
        begin
            if (t[14])
                t = {t[14:0], 1'b0} ^ PEC_POLY;
            else
                t = {t[14:0], 1'b0};
        end
        return {rem[7:0], 8'h00} ^ t;
    endfunction

endpackage

/* rtl/core/cmrd_deframe.sv */
// ----------------------------------------------------------------------------
// cmrd_deframe
// Chunk state, PEC accumulation and result assembly, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module cmrd_deframe
    import cmrd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  item_t              item,
    input  logic [CHAIN_W-1:0] chain_length,
    input  logic               slot_free,
    output logic               step,
    output logic               emit,
    output result_t            result
);

    logic [POS_W-1:0]  byte_position_reg, byte_position_next;
    logic [CHIP_W-1:0] chip_counter_reg, chip_counter_next;
    logic [15:0]       pec_remainder_reg, pec_remainder_next;
    logic [47:0]       data_bytes_reg, data_bytes_next;
    logic [7:0]        pec_high_reg, pec_high_next;

    logic [POS_W-1:0]   pos_eff;
    logic [CHIP_W-1:0]  chip_eff;
    logic [15:0]        rem_eff;
    logic [CHIP_W-1:0]  top;
    logic               is_last;
    logic [CHIP_W-1:0]  chain_pos;
    logic [1:0]         grp;
    logic [INDEX_W-1:0] pos_scaled;
    logic [INDEX_W-1:0] grp_offset;

    // frame start restarts the chunk before the byte is taken
    assign pos_eff  = item.frame_start ? '0 : byte_position_reg;
    assign chip_eff = item.frame_start ? '0 : chip_counter_reg;
    assign rem_eff  = item.frame_start ? PEC_SEED : pec_remainder_reg;

    assign emit = item_valid && (pos_eff == POS_PEC_LOW);
    assign step = item_valid && (!emit || slot_free);

    assign top       = CHIP_W'(chain_length - CHAIN_MIN);
    assign is_last   = chip_eff >= top;
    assign chain_pos = is_last ? '0 : top - chip_eff;
    assign grp       = (item.mode == MODE_AUX) ? {1'b0, item.group[0]} : item.group;

    // stride 12 = 8 + 4, stride 6 = 4 + 2
    always_comb
    begin
        unique case (item.mode)
            MODE_CELL: pos_scaled = {1'b0, chain_pos, 3'b0} + {2'b0, chain_pos, 2'b0};
            MODE_AUX:  pos_scaled = {2'b0, chain_pos, 2'b0} + {3'b0, chain_pos, 1'b0};
            default:   pos_scaled = '0;
        endcase
    end
    assign grp_offset = {5'b0, grp, 1'b0} + {6'b0, grp};

    assign result.code_first  = data_bytes_reg[15:0];
    assign result.code_second = data_bytes_reg[31:16];
    assign result.code_third  = data_bytes_reg[47:32];
    assign result.first_index = pos_scaled + grp_offset;
    assign result.pec_ok      = {pec_high_reg, item.data_byte} == {rem_eff[14:0], 1'b0};
    assign result.last        = is_last;

    always_comb
    begin
        byte_position_next = byte_position_reg;
        chip_counter_next  = chip_counter_reg;
        pec_remainder_next = pec_remainder_reg;
        data_bytes_next    = data_bytes_reg;
        pec_high_next      = pec_high_reg;
        if (step)
        begin
            chip_counter_next  = chip_eff;
            pec_remainder_next = rem_eff;
            priority if (pos_eff < POS_PEC_HIGH)
            begin
                data_bytes_next[pos_eff*8 +: 8] = item.data_byte;
                pec_remainder_next = pec_update(rem_eff, item.data_byte);
                byte_position_next = pos_eff + 1'b1;
            end
            else if (pos_eff == POS_PEC_HIGH)
            begin
                pec_high_next      = item.data_byte;
                byte_position_next = POS_PEC_LOW;
            end
            else
            begin
                byte_position_next = '0;
                pec_remainder_next = PEC_SEED;
                chip_counter_next  = is_last ? '0 : chip_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            chip_counter_reg  <= '0;
            pec_remainder_reg <= PEC_SEED;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            chip_counter_reg  <= chip_counter_next;
            pec_remainder_reg <= pec_remainder_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_bytes_reg <= data_bytes_next;
        pec_high_reg   <= pec_high_next;
    end

`ifndef NO_ASSERTIONS
    a_chain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        chain_length >= CHAIN_MIN && chain_length <= CHAIN_MAX)
        else $error("chain length out of range");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit && result.last |=> chip_counter_reg == '0 && byte_position_reg == '0)
        else $error("last chip did not restart the chain");

    a_data_advances: assert property (@(posedge clk) disable iff (!rst_n)
        step && !emit |=> byte_position_reg != '0)
        else $error("byte position did not advance");
`endif

endmodule

/* rtl/core/cmrd_out_reg.sv */
// ----------------------------------------------------------------------------
// cmrd_out_reg
// Result register holding one transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module cmrd_out_reg
    import cmrd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    out_stall,
    output logic    slot_free,
    output logic    out_valid,
    output result_t out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    assign slot_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
        else if (slot_free)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/cell_monitor_readback_deframer_unit.sv */
// ----------------------------------------------------------------------------
// cell_monitor_readback_deframer_unit
// Deframes daisy-chain monitor readback bytes into checked 16-bit codes.
// ----------------------------------------------------------------------------
// Usage:
//  Byte channel (byte_valid/byte_stall): one response byte per transaction,
//  with mode, group and frame_start. frame_start on the first data byte of
//  a frame restarts the chip and byte counters.
//  Each chip sends 6 data bytes and a 2-byte PEC; the eighth byte of a chunk
//  produces one transaction on the result channel (result_valid/
//  result_stall) with three codes, the array index, pec_ok and last.
//  A byte is captured in an input register and processed from there; its
//  result is loaded into the result register when its eighth byte is taken.
//  One byte is taken per cycle while byte_stall is low; the CRC-15 byte
//  update is combinational between the input and PEC remainder registers.
//  While the receiver stalls a held result, data and PEC-high bytes keep
//  flowing; an eighth byte waits in the input register and byte_stall rises.
//  cfg_wr_en writes chain_length (clamped to 1..16); write only when idle.
//  Reset: chain length 1, counters cleared, PEC seed loaded, no result held.
// ----------------------------------------------------------------------------
module cell_monitor_readback_deframer_unit
    import cmrd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CHAIN_W-1:0] cfg_wr_data,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         data_byte,
    input  logic               mode,
    input  logic [1:0]         group,
    input  logic               frame_start,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [15:0]        code_first,
    output logic [15:0]        code_second,
    output logic [15:0]        code_third,
    output logic [INDEX_W-1:0] first_index,
    output logic               pec_ok,
    output logic               last
);

    logic [CHAIN_W-1:0] chain_length_reg, chain_length_next;
    logic               item_valid_reg, item_valid_next;
    item_t              item_reg, item_next;

    logic    step;
    logic    emit;
    logic    slot_free;
    result_t result;
    result_t out_data;

    always_comb
    begin
        chain_length_next = chain_length_reg;
        if (cfg_wr_en)
        begin
            priority if (cfg_wr_data < CHAIN_MIN)
                chain_length_next = CHAIN_MIN;
            else if (cfg_wr_data > CHAIN_MAX)
                chain_length_next = CHAIN_MAX;
            else
                chain_length_next = cfg_wr_data;
        end
    end

    assign byte_stall = item_valid_reg && !step;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        if (!byte_stall)
        begin
            item_valid_next = byte_valid;
            item_next       = '{data_byte: data_byte, mode: mode, group: group,
                                frame_start: frame_start};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_length_reg <= CHAIN_RESET;
            item_valid_reg   <= 1'b0;
        end
        else
        begin
            chain_length_reg <= chain_length_next;
            item_valid_reg   <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    cmrd_deframe u_deframe (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid_reg),
        .item         (item_reg),
        .chain_length (chain_length_reg),
        .slot_free    (slot_free),
        .step         (step),
        .emit         (emit),
        .result       (result)
    );

    cmrd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && emit),
        .load_data (result),
        .out_stall (result_stall),
        .slot_free (slot_free),
        .out_valid (result_valid),
        .out_data  (out_data)
    );

    assign code_first  = out_data.code_first;
    assign code_second = out_data.code_second;
    assign code_third  = out_data.code_third;
    assign first_index = out_data.first_index;
    assign pec_ok      = out_data.pec_ok;
    assign last        = out_data.last;

endmodule
